// ----- hdl/closest_point_param_two_lines_macros.svh -----
// Assertion helpers shared by the closest-point modules.
`ifndef CLOSEST_POINT_PARAM_TWO_LINES_MACROS_SVH
`define CLOSEST_POINT_PARAM_TWO_LINES_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cpl_pkg.sv -----
package cpl_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int PARAM_WIDTH     = 32;

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int SPLIT_LOW  = SUM_WIDTH / 2;
    localparam int PLO_WIDTH  = SUM_WIDTH + SPLIT_LOW + 1;
    localparam int PHI_WIDTH  = 2 * SUM_WIDTH - SPLIT_LOW;
    localparam int WIDE_WIDTH = 2 * SUM_WIDTH;
    localparam int DEN_WIDTH  = WIDE_WIDTH + 1;
    localparam int QUO_WIDTH  = PARAM_WIDTH + 1;
    localparam int SH_WIDTH   = DEN_WIDTH + PARAM_FRAC_BITS;
    localparam int REM_WIDTH  = DEN_WIDTH + QUO_WIDTH;

    localparam logic [QUO_WIDTH-1:0] POS_LIMIT = QUO_WIDTH'((64'd1 << (PARAM_WIDTH - 1)) - 64'd1);
    localparam logic [QUO_WIDTH-1:0] NEG_LIMIT = QUO_WIDTH'(64'd1 << (PARAM_WIDTH - 1));

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic signed [PLO_WIDTH-1:0]   plo_t;
    typedef logic signed [PHI_WIDTH-1:0]   phi_t;
    typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
    typedef logic signed [DEN_WIDTH-1:0]   den_t;

    // Handoff from the dot-product front end to the divider.
    typedef struct packed {
        logic [SH_WIDTH-1:0]  num_mag;
        logic [DEN_WIDTH-1:0] den;
        logic                 neg;
    } div_in_t;

endpackage

// ----- hdl/closest_point_param_two_lines.sv -----
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    street/probe start and end points, 12 x Q8.8
// m_       out        m_valid/m_ready    m_line_param Q16.16, parallel and saturated flags
//
// One transaction enters per cycle unless the pipeline stalls; each result passes through
// six front-end stages, one divider setup stage, 33 quotient-bit stages, one output stage.
// The restoring divider's 33 quotient-bit stages, one quotient bit a stage, set most of the latency.
// aresetn is synchronous, active low, and clears only the valid bits.
// Stalls fill bubbles first: a stage holds only when it and all later stages are full.
module closest_point_param_two_lines (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_street_start_x,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_street_start_y,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_street_start_z,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_street_end_x,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_street_end_y,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_street_end_z,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_probe_start_x,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_probe_start_y,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_probe_start_z,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_probe_end_x,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_probe_end_y,
    input  logic signed [cpl_pkg::COORD_WIDTH-1:0] s_probe_end_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [cpl_pkg::PARAM_WIDTH-1:0] m_line_param,
    output logic                                   m_parallel_flag,
    output logic                                   m_saturated_flag
);

`include "closest_point_param_two_lines_macros.svh"

    // Signed product with the second operand split in two halves (two narrow multipliers).
    function automatic cpl_pkg::plo_t mul_lo(cpl_pkg::sum_t x, cpl_pkg::sum_t y);
        logic signed [cpl_pkg::SPLIT_LOW:0] ylo;
        ylo = $signed({1'b0, y[cpl_pkg::SPLIT_LOW-1:0]});
        return cpl_pkg::plo_t'(x) * cpl_pkg::plo_t'(ylo);
    endfunction

    function automatic cpl_pkg::phi_t mul_hi(cpl_pkg::sum_t x, cpl_pkg::sum_t y);
        logic signed [cpl_pkg::SUM_WIDTH-cpl_pkg::SPLIT_LOW-1:0] yhi;
        yhi = $signed(y[cpl_pkg::SUM_WIDTH-1:cpl_pkg::SPLIT_LOW]);
        return cpl_pkg::phi_t'(x) * cpl_pkg::phi_t'(yhi);
    endfunction

    function automatic cpl_pkg::den_t join_pp(cpl_pkg::phi_t hi, cpl_pkg::plo_t lo);
        cpl_pkg::wide_t w;
        w = (cpl_pkg::wide_t'(hi) <<< cpl_pkg::SPLIT_LOW) + cpl_pkg::wide_t'(lo);
        return cpl_pkg::den_t'(w);
    endfunction

    logic [6:1] vld_reg;
    logic [7:1] ld;
    logic       div_ready;

    cpl_pkg::coord_t s1 [3];
    cpl_pkg::coord_t s2 [3];
    cpl_pkg::coord_t m1 [3];
    cpl_pkg::coord_t m2 [3];

    // Stage 1: direction and offset vectors.
    cpl_pkg::diff_t du_reg [3];
    cpl_pkg::diff_t dv_reg [3];
    cpl_pkg::diff_t dw_reg [3];
    // Stage 2: element products.
    cpl_pkg::prod_t uu_reg [3];
    cpl_pkg::prod_t uv_reg [3];
    cpl_pkg::prod_t vv_reg [3];
    cpl_pkg::prod_t uw_reg [3];
    cpl_pkg::prod_t vw_reg [3];
    // Stage 3: dot products a..e.
    cpl_pkg::sum_t a_reg, b_reg, c_reg, d_reg, e_reg;
    // Stage 4: split partial products of a*c, b*b, b*e, c*d.
    cpl_pkg::plo_t lo_reg [4];
    cpl_pkg::phi_t hi_reg [4];
    // Stage 5: determinant and numerator.
    cpl_pkg::den_t den_reg, num_reg;
    // Stage 6: numerator magnitude, scaled.
    cpl_pkg::div_in_t div_reg;

    always_comb begin
        s1[0] = s_street_start_x; s1[1] = s_street_start_y; s1[2] = s_street_start_z;
        s2[0] = s_street_end_x;   s2[1] = s_street_end_y;   s2[2] = s_street_end_z;
        m1[0] = s_probe_start_x;  m1[1] = s_probe_start_y;  m1[2] = s_probe_start_z;
        m2[0] = s_probe_end_x;    m2[1] = s_probe_end_y;    m2[2] = s_probe_end_z;
    end

    // Advance a stage when it is empty or its successor advances.
    always_comb begin
        ld[7] = div_ready;
        for (int k = 6; k >= 1; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end
    assign s_ready = ld[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (ld[1]) vld_reg[1] <= s_valid;
            for (int k = 2; k <= 6; k++) begin
                if (ld[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    logic [cpl_pkg::DEN_WIDTH-1:0] num_abs;
    assign num_abs = num_reg[cpl_pkg::DEN_WIDTH-1] ? $unsigned(-num_reg) : $unsigned(num_reg);

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            for (int i = 0; i < 3; i++) begin
                du_reg[i] <= cpl_pkg::diff_t'(s2[i]) - cpl_pkg::diff_t'(s1[i]);
                dv_reg[i] <= cpl_pkg::diff_t'(m2[i]) - cpl_pkg::diff_t'(m1[i]);
                dw_reg[i] <= cpl_pkg::diff_t'(s1[i]) - cpl_pkg::diff_t'(m1[i]);
            end
        end
        if (ld[2]) begin
            for (int i = 0; i < 3; i++) begin
                uu_reg[i] <= cpl_pkg::prod_t'(du_reg[i]) * cpl_pkg::prod_t'(du_reg[i]);
                uv_reg[i] <= cpl_pkg::prod_t'(du_reg[i]) * cpl_pkg::prod_t'(dv_reg[i]);
                vv_reg[i] <= cpl_pkg::prod_t'(dv_reg[i]) * cpl_pkg::prod_t'(dv_reg[i]);
                uw_reg[i] <= cpl_pkg::prod_t'(du_reg[i]) * cpl_pkg::prod_t'(dw_reg[i]);
                vw_reg[i] <= cpl_pkg::prod_t'(dv_reg[i]) * cpl_pkg::prod_t'(dw_reg[i]);
            end
        end
        if (ld[3]) begin
            a_reg <= cpl_pkg::sum_t'(uu_reg[0]) + cpl_pkg::sum_t'(uu_reg[1])
                     + cpl_pkg::sum_t'(uu_reg[2]);
            b_reg <= cpl_pkg::sum_t'(uv_reg[0]) + cpl_pkg::sum_t'(uv_reg[1])
                     + cpl_pkg::sum_t'(uv_reg[2]);
            c_reg <= cpl_pkg::sum_t'(vv_reg[0]) + cpl_pkg::sum_t'(vv_reg[1])
                     + cpl_pkg::sum_t'(vv_reg[2]);
            d_reg <= cpl_pkg::sum_t'(uw_reg[0]) + cpl_pkg::sum_t'(uw_reg[1])
                     + cpl_pkg::sum_t'(uw_reg[2]);
            e_reg <= cpl_pkg::sum_t'(vw_reg[0]) + cpl_pkg::sum_t'(vw_reg[1])
                     + cpl_pkg::sum_t'(vw_reg[2]);
        end
        if (ld[4]) begin
            lo_reg[0] <= mul_lo(a_reg, c_reg); hi_reg[0] <= mul_hi(a_reg, c_reg);
            lo_reg[1] <= mul_lo(b_reg, b_reg); hi_reg[1] <= mul_hi(b_reg, b_reg);
            lo_reg[2] <= mul_lo(b_reg, e_reg); hi_reg[2] <= mul_hi(b_reg, e_reg);
            lo_reg[3] <= mul_lo(c_reg, d_reg); hi_reg[3] <= mul_hi(c_reg, d_reg);
        end
        if (ld[5]) begin
            den_reg <= join_pp(hi_reg[0], lo_reg[0]) - join_pp(hi_reg[1], lo_reg[1]);
            num_reg <= join_pp(hi_reg[2], lo_reg[2]) - join_pp(hi_reg[3], lo_reg[3]);
        end
        if (ld[6]) begin
            // Drop the sign here; the divider works on magnitudes.
            div_reg.neg     <= num_reg[cpl_pkg::DEN_WIDTH-1];
            div_reg.num_mag <= {num_abs, {cpl_pkg::PARAM_FRAC_BITS{1'b0}}};
            div_reg.den     <= $unsigned(den_reg);
        end
    end

    cpl_div u_div (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (vld_reg[6]),
        .in_ready         (div_ready),
        .in_data          (div_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_param     (m_line_param),
        .m_parallel_flag  (m_parallel_flag),
        .m_saturated_flag (m_saturated_flag)
    );

    // The determinant a*c - b*b is never negative.
    `CPL_ASSERT_NOW(a_den_nonneg, aclk, aresetn, vld_reg[6], !div_reg.den[cpl_pkg::DEN_WIDTH-1], "negative determinant")
    // The last front-end stage keeps its transaction while the divider stalls it.
    `CPL_ASSERT_NEXT(a_stage_hold, aclk, aresetn, vld_reg[6] && !div_ready, vld_reg[6] && $stable(div_reg), "front end lost data")
    // Input is taken whenever the first stage is empty.
    `CPL_ASSERT_NOW(a_ready_empty, aclk, aresetn, !vld_reg[1], s_ready, "ready low with empty stage")

endmodule

// ----- hdl/cpl_div.sv -----
module cpl_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cpl_pkg::div_in_t                    in_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [cpl_pkg::PARAM_WIDTH-1:0] m_line_param,
    output logic                                m_parallel_flag,
    output logic                                m_saturated_flag
);

`include "closest_point_param_two_lines_macros.svh"

    localparam int QB = cpl_pkg::QUO_WIDTH;

    typedef struct packed {
        logic [cpl_pkg::REM_WIDTH-1:0] rem;
        logic [cpl_pkg::DEN_WIDTH-1:0] den;
        logic [QB-1:0]                 quo;
        logic                          neg;
        logic                          par;
        logic                          ovf;
    } div_st_t;

    div_st_t     st_reg  [QB+1];
    div_st_t     st_next [QB+1];
    logic [QB:0] vld_reg;
    logic [QB+1:0] ld;

    logic                                   out_valid_reg;
    logic signed [cpl_pkg::PARAM_WIDTH-1:0] out_param_reg;
    logic                                   out_par_reg;
    logic                                   out_sat_reg;

    // A stage loads when empty or when its successor loads.
    always_comb begin
        ld[QB+1] = !out_valid_reg || m_ready;
        for (int k = QB; k >= 0; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end
    assign in_ready = ld[0];

    // Setup stage from the input, then one quotient bit per stage, MSB first.
    always_comb begin
        logic [cpl_pkg::REM_WIDTH-1:0] trial;
        logic                          fit;
        st_next[0].rem = cpl_pkg::REM_WIDTH'(in_data.num_mag);
        st_next[0].den = in_data.den;
        st_next[0].quo = '0;
        st_next[0].neg = in_data.neg;
        st_next[0].par = (in_data.den == '0);
        st_next[0].ovf = (cpl_pkg::REM_WIDTH'(in_data.num_mag)
                          >= {in_data.den, {QB{1'b0}}});
        for (int k = 1; k <= QB; k++) begin
            trial = cpl_pkg::REM_WIDTH'(st_reg[k-1].den) << (QB - k);
            fit   = st_reg[k-1].rem >= trial;
            st_next[k]            = st_reg[k-1];
            st_next[k].rem        = fit ? st_reg[k-1].rem - trial : st_reg[k-1].rem;
            st_next[k].quo[QB-k]  = fit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (ld[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k <= QB; k++) begin
                if (ld[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
        for (int k = 0; k <= QB; k++) begin
            if (ld[k]) st_reg[k] <= st_next[k];
        end
    end

    logic [QB-1:0] limit;
    logic          sat;
    logic [cpl_pkg::PARAM_WIDTH-1:0] mag;
    always_comb begin
        limit = st_reg[QB].neg ? cpl_pkg::NEG_LIMIT : cpl_pkg::POS_LIMIT;
        sat   = st_reg[QB].ovf || (st_reg[QB].quo > limit);
        mag   = sat ? limit[cpl_pkg::PARAM_WIDTH-1:0]
                    : st_reg[QB].quo[cpl_pkg::PARAM_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ld[QB+1]) begin
            out_valid_reg <= vld_reg[QB];
        end
        if (ld[QB+1]) begin
            out_par_reg <= st_reg[QB].par;
            out_sat_reg <= !st_reg[QB].par && sat;
            if (st_reg[QB].par) begin
                out_param_reg <= '0;
            end else if (st_reg[QB].neg) begin
                out_param_reg <= -$signed(mag);
            end else begin
                out_param_reg <= $signed(mag);
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_line_param     = out_param_reg;
    assign m_parallel_flag  = out_par_reg;
    assign m_saturated_flag = out_sat_reg;

    `CPL_ASSERT_NOW(a_par_zero, aclk, aresetn, out_valid_reg && out_par_reg, out_param_reg == '0, "parallel result not zero")
    `CPL_ASSERT_NOW(a_flags_excl, aclk, aresetn, out_valid_reg, !(out_par_reg && out_sat_reg), "both flags set")
    `CPL_ASSERT_NEXT(a_last_hold, aclk, aresetn, vld_reg[QB] && !ld[QB+1], vld_reg[QB], "divider stage dropped")

endmodule
